### design/pal_pkg.sv
// Package for the positional array list: operation and status codes, field widths
// and parameter defaults. No dependencies.
// Used by the channel interfaces and by the top level.
package pal_pkg;

  localparam int unsigned DEPTH_DEF       = 16;
  localparam int unsigned ENTRY_WIDTH_DEF = 32;
  localparam int unsigned OP_W            = 3;
  localparam int unsigned STATUS_W        = 2;

  // Operation codes carried by an input item.
  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 3'd0,
    OP_DELETE   = 3'd1,
    OP_RETRIEVE = 3'd2,
    OP_REPLACE  = 3'd3,
    OP_CLEAR    = 3'd4
  } op_e;

  // Status codes returned with every result item.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

endpackage

### design/pal_if.sv
// Valid/ready channel interfaces for the positional array list.
// Depends on pal_pkg for the code widths and the parameter defaults.
interface pal_in_if #(
  parameter int unsigned CNT_W  = $clog2(pal_pkg::DEPTH_DEF + 1),
  parameter int unsigned DATA_W = pal_pkg::ENTRY_WIDTH_DEF
);
  logic                      valid;
  logic                      ready;
  logic [pal_pkg::OP_W-1:0]  op;
  logic [CNT_W-1:0]          position;
  logic [DATA_W-1:0]         value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface pal_out_if #(
  parameter int unsigned CNT_W  = $clog2(pal_pkg::DEPTH_DEF + 1),
  parameter int unsigned DATA_W = pal_pkg::ENTRY_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   read_value;
  pal_pkg::status_e    status;
  logic [CNT_W-1:0]    count;
  logic                is_empty;
  logic                is_full;

  modport source (output valid, output read_value, output status, output count,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input read_value, input status, input count,
                  input is_empty, input is_full, output ready);
endinterface

### design/positional_array_list.sv
// Top level of the positional array list: sequencer, entry memory and result register.
// Depends on pal_pkg and on the channel interfaces in pal_if.sv.
// The interfaces must be instantiated with CNT_W = $clog2(DEPTH + 1), DATA_W = ENTRY_WIDTH.

// The block keeps an ordered list of up to DEPTH words in a memory with one write
// port and one registered read port. Each input item carries one operation: insert
// a value at a position from 0 to count, delete (and return) the entry at a position
// below count, retrieve an entry, replace an entry, or clear the list. Every item
// yields exactly one result item with a status, the value read, the new count and
// empty and full flags. A bad position, or an insert into a full list, leaves the
// list untouched and is reported in the status. The block works on one item at a
// time and takes no new item until the current one has finished. The shift loop moves
// one entry per cycle through the single memory port pair: an insert reads the top
// entry, shifts the entries from the top down to the position one place up and then
// writes the value (an append writes it at once), a delete reads the entry and
// shifts the entries above it one place down, and a retrieve reads the entry and
// captures the read data. Replace, clear, errors and unknown operations do no read.
// A new item is accepted in the cycle after a result is loaded, even while that
// result still waits for the consumer; the next result is held back until the
// output register is free. The memory needs no clearing after reset, since an
// entry is only ever read after it was written.
module positional_array_list #(
  parameter int unsigned DEPTH       = pal_pkg::DEPTH_DEF,
  parameter int unsigned ENTRY_WIDTH = pal_pkg::ENTRY_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pal_in_if.sink    in_i,
  pal_out_if.source out_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  // Sequencer states. Each shift state moves one entry per cycle.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_WRITE_VAL,
    S_DEL_READ,
    S_SHIFT_DOWN,
    S_RD_WAIT,
    S_FINISH
  } state_e;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       pos_q, pos_d;
  logic [CNT_W-1:0]       idx_q, idx_d;
  logic [ENTRY_WIDTH-1:0] val_q, val_d;
  logic [ENTRY_WIDTH-1:0] rd_val_q, rd_val_d;
  pal_pkg::status_e       status_q, status_d;

  logic                   out_valid_q, out_valid_d;
  logic [ENTRY_WIDTH-1:0] out_rd_q, out_rd_d;
  pal_pkg::status_e       out_status_q, out_status_d;
  logic [CNT_W-1:0]       out_count_q, out_count_d;
  logic                   out_empty_q, out_empty_d;
  logic                   out_full_q, out_full_d;

  // Entry memory with one write port and one registered read port.
  logic [ENTRY_WIDTH-1:0] mem_q [DEPTH];
  logic [ENTRY_WIDTH-1:0] rdata_q;
  logic                   we, re;
  logic [AW-1:0]          waddr, raddr;
  logic [ENTRY_WIDTH-1:0] wdata;

  logic             accept;
  pal_pkg::op_e     op_in;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && (state_q == S_IDLE);
  assign op_in      = pal_pkg::op_e'(in_i.op);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    pos_d        = pos_q;
    idx_d        = idx_q;
    val_d        = val_q;
    rd_val_d     = rd_val_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q;
    out_rd_d     = out_rd_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    out_empty_d  = out_empty_q;
    out_full_d   = out_full_q;
    we           = 1'b0;
    re           = 1'b0;
    waddr        = '0;
    raddr        = '0;
    wdata        = val_q;

    // The consumer takes the waiting result.
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          pos_d    = in_i.position;
          val_d    = in_i.value;
          rd_val_d = '0;
          status_d = pal_pkg::ST_OK;
          state_d  = S_FINISH;
          case (op_in)
            pal_pkg::OP_INSERT: begin
              // The position check comes before the full check.
              if (in_i.position > count_q) begin
                status_d = pal_pkg::ST_BAD_POS;
              end else if (count_q == DEPTH_C) begin
                status_d = pal_pkg::ST_FULL;
              end else if (in_i.position == count_q) begin
                // Appending needs no shift.
                we      = 1'b1;
                waddr   = in_i.position[AW-1:0];
                wdata   = in_i.value;
                count_d = count_q + CNT_W'(1);
              end else begin
                // Start moving entries up from the top of the list.
                re      = 1'b1;
                raddr   = AW'(count_q - CNT_W'(1));
                idx_d   = count_q;
                state_d = S_SHIFT_UP;
              end
            end
            pal_pkg::OP_DELETE: begin
              if (in_i.position >= count_q) begin
                status_d = pal_pkg::ST_BAD_POS;
              end else begin
                re      = 1'b1;
                raddr   = in_i.position[AW-1:0];
                state_d = S_DEL_READ;
              end
            end
            pal_pkg::OP_RETRIEVE: begin
              if (in_i.position >= count_q) begin
                status_d = pal_pkg::ST_BAD_POS;
              end else begin
                re      = 1'b1;
                raddr   = in_i.position[AW-1:0];
                state_d = S_RD_WAIT;
              end
            end
            pal_pkg::OP_REPLACE: begin
              if (in_i.position >= count_q) begin
                status_d = pal_pkg::ST_BAD_POS;
              end else begin
                we    = 1'b1;
                waddr = in_i.position[AW-1:0];
                wdata = in_i.value;
              end
            end
            pal_pkg::OP_CLEAR: begin
              count_d = '0;
            end
            default: begin
              // Unknown operations change nothing and report success.
            end
          endcase
        end
      end

      S_SHIFT_UP: begin
        // Entry idx-1 arrives from the read port and lands one place higher.
        we    = 1'b1;
        waddr = idx_q[AW-1:0];
        wdata = rdata_q;
        if ((idx_q - CNT_W'(1)) == pos_q) begin
          state_d = S_WRITE_VAL;
        end else begin
          re    = 1'b1;
          raddr = AW'(idx_q - CNT_W'(2));
          idx_d = idx_q - CNT_W'(1);
        end
      end

      S_WRITE_VAL: begin
        we      = 1'b1;
        waddr   = pos_q[AW-1:0];
        wdata   = val_q;
        count_d = count_q + CNT_W'(1);
        state_d = S_FINISH;
      end

      S_DEL_READ: begin
        rd_val_d = rdata_q;
        if ((pos_q + CNT_W'(1)) < count_q) begin
          re      = 1'b1;
          raddr   = AW'(pos_q + CNT_W'(1));
          idx_d   = pos_q + CNT_W'(1);
          state_d = S_SHIFT_DOWN;
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = S_FINISH;
        end
      end

      S_SHIFT_DOWN: begin
        // Entry idx arrives from the read port and lands one place lower.
        we    = 1'b1;
        waddr = AW'(idx_q - CNT_W'(1));
        wdata = rdata_q;
        if ((idx_q + CNT_W'(1)) < count_q) begin
          re    = 1'b1;
          raddr = AW'(idx_q + CNT_W'(1));
          idx_d = idx_q + CNT_W'(1);
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = S_FINISH;
        end
      end

      S_RD_WAIT: begin
        rd_val_d = rdata_q;
        state_d  = S_FINISH;
      end

      S_FINISH: begin
        // Load the result once the output register is free.
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_rd_d     = rd_val_q;
          out_status_d = status_q;
          out_count_d  = count_q;
          out_empty_d  = (count_q == '0);
          out_full_d   = (count_q == DEPTH_C);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      pos_q        <= '0;
      idx_q        <= '0;
      val_q        <= '0;
      rd_val_q     <= '0;
      status_q     <= pal_pkg::ST_OK;
      out_valid_q  <= 1'b0;
      out_rd_q     <= '0;
      out_status_q <= pal_pkg::ST_OK;
      out_count_q  <= '0;
      out_empty_q  <= 1'b1;
      out_full_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      pos_q        <= pos_d;
      idx_q        <= idx_d;
      val_q        <= val_d;
      rd_val_q     <= rd_val_d;
      status_q     <= status_d;
      out_valid_q  <= out_valid_d;
      out_rd_q     <= out_rd_d;
      out_status_q <= out_status_d;
      out_count_q  <= out_count_d;
      out_empty_q  <= out_empty_d;
      out_full_q   <= out_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_value = out_rd_q;
  assign out_o.status     = out_status_q;
  assign out_o.count      = out_count_q;
  assign out_o.is_empty   = out_empty_q;
  assign out_o.is_full    = out_full_q;

  // The list never holds more than DEPTH entries.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("entry count exceeds the list depth");

  // A failed operation never returns data.
  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status != pal_pkg::ST_OK) |-> out_o.read_value == '0)
    else $error("error result carries a read value");

  // With no item in flight and none offered, the count stays put.
  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) && !in_i.valid |=> $stable(count_q))
    else $error("entry count changed while idle");

endmodule
